FILE: hw/rtl/ost_pkg.sv
`timescale 1ns / 1ps

package ost_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam logic [3:0] TAB_WEIGHT_RESET = 4'd2;

    typedef enum logic [4:0] {
        KIND_PLUS,
        KIND_MINUS,
        KIND_STAR,
        KIND_SLASH,
        KIND_PERCENT,
        KIND_GT,
        KIND_GE,
        KIND_SHR,
        KIND_LT,
        KIND_LE,
        KIND_SHL,
        KIND_BANG,
        KIND_NE,
        KIND_AMP,
        KIND_AND,
        KIND_BAR,
        KIND_OR,
        KIND_COLON,
        KIND_ASSIGN,
        KIND_EQ,
        KIND_LPAREN,
        KIND_RPAREN,
        KIND_LBRACK,
        KIND_RBRACK,
        KIND_LBRACE,
        KIND_RBRACE,
        KIND_STRING,
        KIND_EOF,
        KIND_INVALID,
        KIND_UNTERM
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  indent;
        logic [15:0] length;
        logic [15:0] errors;
        logic        last;
    } result_t;

endpackage

FILE: hw/rtl/ost_core.sv
`timescale 1ns / 1ps

module ost_core #(
    parameter int POSITION_BITS = ost_pkg::POSITION_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       ch,
    input  logic             end_of_text,
    input  logic [3:0]       tab_weight,
    output ost_pkg::result_t res0,
    output ost_pkg::result_t res1,
    output logic [1:0]       n_res
);
    import ost_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int WW = (PB > 16) ? PB : 17;
    localparam logic [PB-1:0] POS_MAX = '1;
    localparam logic [PB-1:0] POS_ONE = PB'(1);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_RBRC  = 8'h7D;
    localparam logic [7:0] CH_NONE  = 8'h00;

    typedef enum logic [1:0] {MODE_NORMAL, MODE_STRING, MODE_COMMENT} mode_t;
    typedef enum logic [2:0] {
        PEND_NONE, PEND_GT, PEND_LT, PEND_BANG, PEND_AMP, PEND_BAR, PEND_EQ, PEND_SLASH
    } pend_t;

    function automatic pend_t pend_of(logic [7:0] c);
        pend_t p;
        case (c)
            CH_GT:    p = PEND_GT;
            CH_LT:    p = PEND_LT;
            CH_BANG:  p = PEND_BANG;
            CH_AMP:   p = PEND_AMP;
            CH_BAR:   p = PEND_BAR;
            CH_EQ:    p = PEND_EQ;
            CH_SLASH: p = PEND_SLASH;
            default:  p = PEND_NONE;
        endcase
        return p;
    endfunction

    // KIND_INVALID means the byte is not a one-character token
    function automatic kind_t single_of(logic [7:0] c);
        kind_t k;
        case (c)
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_STAR:  k = KIND_STAR;
            CH_PCT:   k = KIND_PERCENT;
            CH_COLON: k = KIND_COLON;
            CH_LPAR:  k = KIND_LPAREN;
            CH_RPAR:  k = KIND_RPAREN;
            CH_LBRK:  k = KIND_LBRACK;
            CH_RBRK:  k = KIND_RBRACK;
            CH_LBRC:  k = KIND_LBRACE;
            CH_RBRC:  k = KIND_RBRACE;
            default:  k = KIND_INVALID;
        endcase
        return k;
    endfunction

    function automatic kind_t pend_kind(pend_t p);
        kind_t k;
        case (p)
            PEND_GT:    k = KIND_GT;
            PEND_LT:    k = KIND_LT;
            PEND_BANG:  k = KIND_BANG;
            PEND_AMP:   k = KIND_AMP;
            PEND_BAR:   k = KIND_BAR;
            PEND_EQ:    k = KIND_ASSIGN;
            PEND_SLASH: k = KIND_SLASH;
            default:    k = KIND_PLUS;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] partner_a(pend_t p);
        logic [7:0] c;
        case (p)
            PEND_GT, PEND_LT, PEND_BANG, PEND_EQ: c = CH_EQ;
            PEND_AMP:   c = CH_AMP;
            PEND_BAR:   c = CH_BAR;
            PEND_SLASH: c = CH_SLASH;
            default:    c = CH_NONE;
        endcase
        return c;
    endfunction

    function automatic kind_t kind_a(pend_t p);
        kind_t k;
        case (p)
            PEND_GT:   k = KIND_GE;
            PEND_LT:   k = KIND_LE;
            PEND_BANG: k = KIND_NE;
            PEND_AMP:  k = KIND_AND;
            PEND_BAR:  k = KIND_OR;
            PEND_EQ:   k = KIND_EQ;
            default:   k = KIND_PLUS;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] partner_b(pend_t p);
        logic [7:0] c;
        case (p)
            PEND_GT: c = CH_GT;
            PEND_LT: c = CH_LT;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    function automatic kind_t kind_b(pend_t p);
        return (p == PEND_GT) ? KIND_SHR : KIND_SHL;
    endfunction

    function automatic logic [15:0] clamp16(logic [PB-1:0] v);
        logic [WW-1:0] ext;
        ext = WW'(v);
        return (ext > WW'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic result_t mk(kind_t k, logic [15:0] ln, logic [PB-1:0] col,
                                   logic [7:0] ind, logic [15:0] len, logic [15:0] err);
        result_t r;
        r.kind   = k;
        r.line   = ln;
        r.column = clamp16(col);
        r.indent = ind;
        r.length = len;
        r.errors = err;
        r.last   = 1'b0;
        return r;
    endfunction

    mode_t          mode_reg,   mode_next;
    pend_t          pend_reg,   pend_next;
    logic [PB-1:0]  pcol_reg,   pcol_next;
    logic [PB-1:0]  line_reg,   line_next;
    logic [PB-1:0]  col_reg,    col_next;
    logic [7:0]     indent_reg, indent_next;
    logic           als_reg,    als_next;
    logic [PB-1:0]  sstart_reg, sstart_next;
    logic [15:0]    scount_reg, scount_next;
    logic [15:0]    err_reg,    err_next;

    logic           is_end;
    logic [PB-1:0]  col_inc, line_inc;
    logic [15:0]    err_inc, scount_inc, line_o;
    logic [8:0]     indent_sum;
    logic [7:0]     indent_sat;

    // plain byte handling, used directly or after a pending operator falls back
    mode_t          nb_mode;
    pend_t          nb_pend;
    logic [PB-1:0]  nb_pcol, nb_line, nb_col, nb_sstart;
    logic [7:0]     nb_indent;
    logic           nb_als, nb_emit;
    logic [15:0]    nb_scount, nb_err;
    result_t        nb_res;

    result_t        r0, r1;
    logic [1:0]     n;
    logic           use_nb;

    assign is_end     = end_of_text || (ch == CH_NONE);
    assign col_inc    = (col_reg != POS_MAX) ? col_reg + POS_ONE : col_reg;
    assign line_inc   = (line_reg != POS_MAX) ? line_reg + POS_ONE : line_reg;
    assign err_inc    = (err_reg != 16'hFFFF) ? err_reg + 16'd1 : err_reg;
    assign scount_inc = (scount_reg != 16'hFFFF) ? scount_reg + 16'd1 : scount_reg;
    assign indent_sum = {1'b0, indent_reg} + ((ch == CH_TAB) ? {5'd0, tab_weight} : 9'd1);
    assign indent_sat = indent_sum[8] ? 8'hFF : indent_sum[7:0];
    assign line_o     = clamp16(line_reg);

    always_comb
    begin
        nb_mode   = MODE_NORMAL;
        nb_pend   = PEND_NONE;
        nb_pcol   = pcol_reg;
        nb_line   = line_reg;
        nb_col    = col_inc;
        nb_indent = indent_reg;
        nb_als    = 1'b0;
        nb_sstart = sstart_reg;
        nb_scount = scount_reg;
        nb_err    = err_reg;
        nb_emit   = 1'b0;
        nb_res    = mk(single_of(ch), line_o, col_reg, indent_reg, 16'd0, err_reg);
        if (ch == CH_SPACE || ch == CH_TAB)
        begin
            nb_als = als_reg;
            if (als_reg)
            begin
                nb_indent = indent_sat;
            end
        end
        else if (ch == CH_NL)
        begin
            nb_line   = line_inc;
            nb_col    = POS_ONE;
            nb_indent = 8'd0;
            nb_als    = 1'b1;
        end
        else if (ch == CH_QUOTE)
        begin
            nb_mode   = MODE_STRING;
            nb_sstart = col_reg;
            nb_scount = 16'd0;
        end
        else if (pend_of(ch) != PEND_NONE)
        begin
            nb_pend = pend_of(ch);
            nb_pcol = col_reg;
        end
        else if (single_of(ch) == KIND_INVALID)
        begin
            nb_err  = err_inc;
            nb_emit = 1'b1;
            nb_res  = mk(KIND_INVALID, line_o, col_reg, indent_reg, 16'd0, err_inc);
        end
        else
        begin
            nb_emit = 1'b1;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        pcol_next   = pcol_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        indent_next = indent_reg;
        als_next    = als_reg;
        sstart_next = sstart_reg;
        scount_next = scount_reg;
        err_next    = err_reg;
        r0          = nb_res;
        r1          = nb_res;
        n           = 2'd0;
        use_nb      = 1'b0;

        if (is_end)
        begin
            // pending operator and open string never coexist
            if (pend_reg != PEND_NONE)
            begin
                r0 = mk(pend_kind(pend_reg), line_o, pcol_reg, indent_reg, 16'd0, err_reg);
                n  = 2'd1;
            end
            else if (mode_reg == MODE_STRING)
            begin
                r0 = mk(KIND_UNTERM, line_o, sstart_reg, indent_reg, scount_reg, err_inc);
                n  = 2'd1;
            end
            if (n == 2'd0)
            begin
                r0 = mk(KIND_EOF, line_o, col_reg, 8'd0, 16'd0,
                        (mode_reg == MODE_STRING) ? err_inc : err_reg);
                n  = 2'd1;
            end
            else
            begin
                r1 = mk(KIND_EOF, line_o, col_reg, 8'd0, 16'd0,
                        (mode_reg == MODE_STRING) ? err_inc : err_reg);
                n  = 2'd2;
            end
            mode_next   = MODE_NORMAL;
            pend_next   = PEND_NONE;
            pcol_next   = '0;
            line_next   = POS_ONE;
            col_next    = POS_ONE;
            indent_next = 8'd0;
            als_next    = 1'b1;
            sstart_next = '0;
            scount_next = 16'd0;
            err_next    = 16'd0;
        end
        else if (mode_reg == MODE_COMMENT)
        begin
            if (ch == CH_NL)
            begin
                mode_next   = MODE_NORMAL;
                line_next   = line_inc;
                col_next    = POS_ONE;
                indent_next = 8'd0;
                als_next    = 1'b1;
            end
        end
        else if (mode_reg == MODE_STRING)
        begin
            if (ch == CH_QUOTE)
            begin
                r0        = mk(KIND_STRING, line_o, sstart_reg, indent_reg, scount_reg, err_reg);
                n         = 2'd1;
                col_next  = col_inc;
                mode_next = MODE_NORMAL;
            end
            else if (ch == CH_NL)
            begin
                r0          = mk(KIND_UNTERM, line_o, sstart_reg, indent_reg, scount_reg,
                                 err_inc);
                n           = 2'd1;
                err_next    = err_inc;
                mode_next   = MODE_NORMAL;
                line_next   = line_inc;
                col_next    = POS_ONE;
                indent_next = 8'd0;
                als_next    = 1'b1;
            end
            else
            begin
                scount_next = scount_inc;
                col_next    = col_inc;
            end
        end
        else if (pend_reg != PEND_NONE)
        begin
            pend_next = PEND_NONE;
            if (pend_reg == PEND_SLASH && ch == CH_SLASH)
            begin
                mode_next = MODE_COMMENT;
            end
            else if (ch == partner_a(pend_reg))
            begin
                r0       = mk(kind_a(pend_reg), line_o, pcol_reg, indent_reg, 16'd0, err_reg);
                n        = 2'd1;
                col_next = col_inc;
            end
            else if (partner_b(pend_reg) != CH_NONE && ch == partner_b(pend_reg))
            begin
                r0       = mk(kind_b(pend_reg), line_o, pcol_reg, indent_reg, 16'd0, err_reg);
                n        = 2'd1;
                col_next = col_inc;
            end
            else
            begin
                r0     = mk(pend_kind(pend_reg), line_o, pcol_reg, indent_reg, 16'd0, err_reg);
                r1     = nb_res;
                n      = nb_emit ? 2'd2 : 2'd1;
                use_nb = 1'b1;
            end
        end
        else
        begin
            r0     = nb_res;
            n      = nb_emit ? 2'd1 : 2'd0;
            use_nb = 1'b1;
        end

        if (use_nb)
        begin
            mode_next   = nb_mode;
            pend_next   = nb_pend;
            pcol_next   = nb_pcol;
            line_next   = nb_line;
            col_next    = nb_col;
            indent_next = nb_indent;
            als_next    = nb_als;
            sstart_next = nb_sstart;
            scount_next = nb_scount;
            err_next    = nb_err;
        end
    end

    always_comb
    begin
        res0      = r0;
        res1      = r1;
        res0.last = (n == 2'd1);
        res1.last = (n == 2'd2);
        n_res     = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            pend_reg   <= PEND_NONE;
            pcol_reg   <= '0;
            line_reg   <= POS_ONE;
            col_reg    <= POS_ONE;
            indent_reg <= 8'd0;
            als_reg    <= 1'b1;
            sstart_reg <= '0;
            scount_reg <= 16'd0;
            err_reg    <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            pcol_reg   <= pcol_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            indent_reg <= indent_next;
            als_reg    <= als_next;
            sstart_reg <= sstart_next;
            scount_reg <= scount_next;
            err_reg    <= err_next;
        end
    end

`ifndef SYNTH
    // a held operator only exists in normal scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_STRING || mode_reg == MODE_COMMENT) |-> (pend_reg == PEND_NONE))
        else $error("pending operator held outside normal mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |=> (mode_reg == MODE_NORMAL && line_reg == POS_ONE
                                && col_reg == POS_ONE && err_reg == 16'd0))
        else $error("end word did not restore scan state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_end) |-> (n_res != 2'd0 && (n == 2'd1 ? r0.kind == KIND_EOF
                                                            : r1.kind == KIND_EOF)))
        else $error("end word without EOF as final token");
`endif

endmodule

FILE: hw/rtl/ost_outq.sv
`timescale 1ns / 1ps

module ost_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             accept,
    input  logic [1:0]       n_push,
    input  ost_pkg::result_t res0,
    input  ost_pkg::result_t res1,
    output logic             out_valid,
    input  logic             out_stall,
    output ost_pkg::result_t head
);
    import ost_pkg::*;

    localparam int QDEPTH = 3;

    result_t    q_reg  [QDEPTH];
    result_t    q_next [QDEPTH];
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] cnt_after;
    logic       pop;

    // room for two more words once at most one is queued
    assign in_stall  = (cnt_reg >= 2'd2);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (cnt_reg != 2'd0);
    assign head      = q_reg[0];
    assign pop       = out_valid && !out_stall;
    assign cnt_after = cnt_reg - {1'b0, pop};

    always_comb
    begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = pop ? q_reg[2] : q_reg[1];
        q_next[2] = q_reg[2];
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (accept && cnt_after == 2'(i))
            begin
                q_next[i] = res0;
            end
            if (accept && n_push == 2'd2 && (cnt_after + 2'd1) == 2'(i))
            begin
                q_next[i] = res1;
            end
        end
        cnt_next = cnt_after + (accept ? n_push : 2'd0);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && n_push == 2'd2 && cnt_reg == 2'd1 && out_stall) |=> (cnt_reg == 2'd3))
        else $error("two-word push into stalled queue lost a word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && cnt_reg > 2'd1) |=> (q_reg[0] == $past(q_reg[1])))
        else $error("queue did not advance after pop");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && n_push != 2'd0) |=> out_valid)
        else $error("pushed word not visible");
`endif

endmodule

FILE: hw/rtl/operator_string_tokenizer_top.sv
`timescale 1ns / 1ps

// Operator and string tokenizer.
// Input channel: one source byte per word (ch), or an end word (end_of_text
// high, or ch zero) that flushes pending work, gives EOF and clears the scan
// state. A word moves when in_valid is high and in_stall is low.
// Output channel: one token per word on token_kind, line, column, indent,
// string_length, error_total; last marks the final token of an input word.
// A word moves when out_valid is high and out_stall is low.
// Config channel: cfg_data sets the indentation added by a leading tab;
// cfg_ready is always high.
// Tokens are registered in the output queue before they reach the output.
// Throughput: one byte per cycle while the output is not stalled; a byte that
// gives two tokens holds the input while the three-word output queue drains.
// When the receiver stalls, up to three tokens wait in the queue and input
// is stalled once two are queued. Reset empties the queue, restores line 1,
// column 1, zero errors and tab weight 2.
module operator_string_tokenizer_top #(
    parameter int POSITION_BITS = ost_pkg::POSITION_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] line,
    output logic [15:0] column,
    output logic [7:0]  indent,
    output logic [15:0] string_length,
    output logic [15:0] error_total,
    output logic        last
);
    import ost_pkg::*;

    logic [3:0] weight_reg;
    logic       accept;
    logic [1:0] n_res;
    result_t    res0, res1, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= TAB_WEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            weight_reg <= cfg_data;
        end
    end

    ost_core #(
        .POSITION_BITS(POSITION_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .ch         (ch),
        .end_of_text(end_of_text),
        .tab_weight (weight_reg),
        .res0       (res0),
        .res1       (res1),
        .n_res      (n_res)
    );

    ost_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .accept   (accept),
        .n_push   (n_res),
        .res0     (res0),
        .res1     (res1),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .head     (head)
    );

    assign token_kind    = head.kind;
    assign line          = head.line;
    assign column        = head.column;
    assign indent        = head.indent;
    assign string_length = head.length;
    assign error_total   = head.errors;
    assign last          = head.last;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import ost_pkg::*;

    typedef enum logic [1:0] {SCAN_CODE, SCAN_QUOTE, SCAN_REMARK} scan_t;
    typedef enum logic [1:0] {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_PATTERN} drain_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } word_t;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_BAR     = 8'h7C;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    localparam int OP_COUNT = 18;
    localparam logic [8*OP_COUNT-1:0] OP_CHARS = "+-*/%:()[]{}><!&|=";
    localparam logic [3:0] WEIGHT_PLAN [4] = '{4'd15, 4'd0, 4'd8, 4'd1};
    localparam int PHASES = 6;
    localparam int WORDS_PER_PHASE = 300;
    localparam int HOLD_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = 4'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  ch = 8'd0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  token_kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  indent;
    logic [15:0] string_length;
    logic [15:0] error_total;
    logic        last;

    operator_string_tokenizer_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .ch            (ch),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .token_kind    (token_kind),
        .line          (line),
        .column        (column),
        .indent        (indent),
        .string_length (string_length),
        .error_total   (error_total),
        .last          (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // scanner state mirrored by the predictor
    logic [3:0]  tab_weight;
    scan_t       scan_mode;
    logic [7:0]  held_op;       // operator char waiting for a partner, NUL if none
    logic [15:0] held_col;
    logic [15:0] line_no;
    logic [15:0] col_no;
    logic [7:0]  indent_lvl;
    logic        line_start;
    logic [15:0] quote_col;
    logic [15:0] quote_len;
    logic [15:0] err_cnt;

    result_t tokens_due[$];
    word_t   words_out[$];
    int      words_made = 0;
    int      fail_count = 0;
    logic    word_taken = 1'b0;

    task automatic clear_scan();
        scan_mode  = SCAN_CODE;
        held_op    = CH_NUL;
        held_col   = 16'd0;
        line_no    = 16'd1;
        col_no     = 16'd1;
        indent_lvl = 8'd0;
        line_start = 1'b1;
        quote_col  = 16'd0;
        quote_len  = 16'd0;
        err_cnt    = 16'd0;
    endtask

    task automatic push_token(kind_t k, logic [15:0] col, logic [7:0] ind, logic [15:0] len);
        result_t t;
        t.kind   = k;
        t.line   = line_no;
        t.column = col;
        t.indent = ind;
        t.length = len;
        t.errors = err_cnt;
        t.last   = 1'b0;
        tokens_due.push_back(t);
    endtask

    task automatic step_column();
        if (col_no != 16'hFFFF)
            col_no++;
    endtask

    task automatic bump_errors();
        if (err_cnt != 16'hFFFF)
            err_cnt++;
    endtask

    task automatic new_line();
        if (line_no != 16'hFFFF)
            line_no++;
        col_no     = 16'd1;
        indent_lvl = 8'd0;
        line_start = 1'b1;
    endtask

    function automatic kind_t lone_kind(logic [7:0] c);
        case (c)
            CH_GT:   return KIND_GT;
            CH_LT:   return KIND_LT;
            CH_BANG: return KIND_BANG;
            CH_AMP:  return KIND_AMP;
            CH_BAR:  return KIND_BAR;
            CH_EQ:   return KIND_ASSIGN;
            default: return KIND_SLASH;
        endcase
    endfunction

    function automatic kind_t plain_kind(logic [7:0] c);
        case (c)
            CH_PLUS:    return KIND_PLUS;
            CH_MINUS:   return KIND_MINUS;
            CH_STAR:    return KIND_STAR;
            CH_PERCENT: return KIND_PERCENT;
            CH_COLON:   return KIND_COLON;
            CH_LPAREN:  return KIND_LPAREN;
            CH_RPAREN:  return KIND_RPAREN;
            CH_LBRACK:  return KIND_LBRACK;
            CH_RBRACK:  return KIND_RBRACK;
            CH_LBRACE:  return KIND_LBRACE;
            CH_RBRACE:  return KIND_RBRACE;
            default:    return KIND_INVALID;
        endcase
    endfunction

    // byte seen in code mode with no operator held
    task automatic take_plain(logic [7:0] c);
        kind_t k;
        int    lvl;
        if (c == CH_SPACE || c == CH_TAB)
        begin
            if (line_start)
            begin
                lvl = int'(indent_lvl) + ((c == CH_TAB) ? int'(tab_weight) : 1);
                indent_lvl = (lvl > 255) ? 8'd255 : lvl[7:0];
            end
            step_column();
        end
        else if (c == CH_NL)
        begin
            new_line();
        end
        else
        begin
            line_start = 1'b0;
            case (c)
                CH_QUOTE:
                begin
                    scan_mode = SCAN_QUOTE;
                    quote_col = col_no;
                    quote_len = 16'd0;
                end
                CH_GT, CH_LT, CH_BANG, CH_AMP, CH_BAR, CH_EQ, CH_SLASH:
                begin
                    held_op  = c;
                    held_col = col_no;
                end
                default:
                begin
                    k = plain_kind(c);
                    if (k == KIND_INVALID)
                        bump_errors();
                    push_token(k, col_no, indent_lvl, 16'd0);
                end
            endcase
            step_column();
        end
    endtask

    task automatic scan_word(logic [7:0] c, logic eot);
        int         first_new;
        logic [7:0] first;
        kind_t      k;
        logic       fused;
        result_t    t;
        first_new = tokens_due.size();
        if (eot || c == CH_NUL)
        begin
            if (held_op != CH_NUL)
                push_token(lone_kind(held_op), held_col, indent_lvl, 16'd0);
            if (scan_mode == SCAN_QUOTE)
            begin
                bump_errors();
                push_token(KIND_UNTERM, quote_col, indent_lvl, quote_len);
            end
            push_token(KIND_EOF, col_no, 8'd0, 16'd0);
            clear_scan();
        end
        else if (scan_mode == SCAN_REMARK)
        begin
            if (c == CH_NL)
            begin
                scan_mode = SCAN_CODE;
                new_line();
            end
        end
        else if (scan_mode == SCAN_QUOTE)
        begin
            if (c == CH_QUOTE)
            begin
                push_token(KIND_STRING, quote_col, indent_lvl, quote_len);
                step_column();
                scan_mode = SCAN_CODE;
            end
            else if (c == CH_NL)
            begin
                bump_errors();
                push_token(KIND_UNTERM, quote_col, indent_lvl, quote_len);
                scan_mode = SCAN_CODE;
                new_line();
            end
            else
            begin
                if (quote_len != 16'hFFFF)
                    quote_len++;
                step_column();
            end
        end
        else if (held_op != CH_NUL)
        begin
            first   = held_op;
            held_op = CH_NUL;
            k       = lone_kind(first);
            fused   = 1'b1;
            case (first)
                CH_GT:
                    if (c == CH_EQ) k = KIND_GE;
                    else if (c == CH_GT) k = KIND_SHR;
                    else fused = 1'b0;
                CH_LT:
                    if (c == CH_EQ) k = KIND_LE;
                    else if (c == CH_LT) k = KIND_SHL;
                    else fused = 1'b0;
                CH_BANG: if (c == CH_EQ) k = KIND_NE; else fused = 1'b0;
                CH_AMP:  if (c == CH_AMP) k = KIND_AND; else fused = 1'b0;
                CH_BAR:  if (c == CH_BAR) k = KIND_OR; else fused = 1'b0;
                CH_EQ:   if (c == CH_EQ) k = KIND_EQ; else fused = 1'b0;
                default: fused = 1'b0;
            endcase
            if (first == CH_SLASH && c == CH_SLASH)
            begin
                // second slash opens a comment without moving the column
                scan_mode = SCAN_REMARK;
            end
            else if (fused)
            begin
                push_token(k, held_col, indent_lvl, 16'd0);
                step_column();
            end
            else
            begin
                push_token(k, held_col, indent_lvl, 16'd0);
                take_plain(c);
            end
        end
        else
        begin
            take_plain(c);
        end
        if (tokens_due.size() > first_new)
        begin
            t = tokens_due.pop_back();
            t.last = 1'b1;
            tokens_due.push_back(t);
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // prediction first, so a token of the word taken at this edge is already queued
    always @(posedge clk)
    begin : watch_out
        result_t want;
        if (rst_n)
        begin
            word_taken <= in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
                tab_weight = cfg_data;
            if (in_valid && !in_stall)
                scan_word(ch, end_of_text);
            if (out_valid && !out_stall)
            begin
                if (tokens_due.size() == 0)
                begin
                    $error("token with nothing due: kind %0d line %0d column %0d",
                           token_kind, line, column);
                    fail_count++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    check_field("token_kind", want.kind, token_kind);
                    check_field("line", want.line, line);
                    check_field("column", want.column, column);
                    check_field("indent", want.indent, indent);
                    check_field("string_length", want.length, string_length);
                    check_field("error_total", want.errors, error_total);
                    check_field("last", want.last, last);
                end
            end
        end
    end

    // sender: bursts of random length, random gaps between them
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin : feed
        word_t w;
        if (!in_valid || word_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (words_out.size() > 0)
            begin
                w = words_out.pop_front();
                ch          <= w.ch;
                end_of_text <= w.eot;
                in_valid    <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall patterns, redrawn as the run goes on; long hold on request
    int         hold_asks = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         rx_cyc = 0;
    drain_t     rx_mode = DRAIN_FREE;
    logic [7:0] rx_mask = 8'd0;

    always @(negedge clk)
    begin : drain
        rx_cyc++;
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (rx_cyc % 300 == 0)
        begin
            rx_mode = drain_t'($urandom_range(0, 3));
            rx_mask = 8'($urandom);
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                DRAIN_FREE:  out_stall <= 1'b0;
                DRAIN_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                DRAIN_HEAVY: out_stall <= ($urandom_range(0, 2) != 0);
                default:     out_stall <= rx_mask[rx_cyc % 8];
            endcase
        end
    end

    task automatic push_word(logic [7:0] c, logic eot);
        word_t w;
        w.ch  = c;
        w.eot = eot;
        words_out.push_back(w);
        words_made++;
    endtask

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_word(8'(s[i]), 1'b0);
    endtask

    task automatic push_end();
        logic eot;
        eot = 1'($urandom_range(0, 1));
        push_word(eot ? 8'($urandom_range(0, 255)) : CH_NUL, eot);
    endtask

    // body of a string or comment: never a quote, newline or NUL
    task automatic push_body();
        int         n;
        logic [7:0] c;
        n = $urandom_range(0, 6);
        repeat (n)
        begin
            c = CH_QUOTE;
            while (c == CH_QUOTE || c == CH_NL)
                c = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(32, 126))
                                                : 8'($urandom_range(1, 255));
            push_word(c, 1'b0);
        end
    endtask

    task automatic push_random_line();
        int   n;
        int   pick;
        int   idx;
        logic stop;
        stop = 1'b0;
        n = $urandom_range(0, 4);
        repeat (n)
            push_word(($urandom_range(0, 1) != 0) ? CH_TAB : CH_SPACE, 1'b0);
        n = $urandom_range(0, 8);
        for (int i = 0; i < n && !stop; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                idx = $urandom_range(0, OP_COUNT - 1);
                push_word(OP_CHARS[8*idx +: 8], 1'b0);
            end
            else if (pick < 62)
                push_word(CH_SPACE, 1'b0);
            else if (pick < 76)
            begin
                push_word(CH_QUOTE, 1'b0);
                push_body();
                push_word(CH_QUOTE, 1'b0);
            end
            else if (pick < 83)
                push_word(8'($urandom_range(1, 255)), 1'b0);
            else if (pick < 89)
            begin
                push_word(CH_SLASH, 1'b0);
                push_word(CH_SLASH, 1'b0);
                push_body();
                stop = 1'b1;
            end
            else if (pick < 94)
            begin
                // open string, closed by the newline or an end word
                push_word(CH_QUOTE, 1'b0);
                push_body();
                if ($urandom_range(0, 2) == 0)
                    push_end();
                stop = 1'b1;
            end
            else
                push_end();
        end
        push_word(CH_NL, 1'b0);
    endtask

    task automatic wait_drained();
        while (words_out.size() != 0 || in_valid || tokens_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_weight(logic [3:0] w);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int target;
        clear_scan();
        tab_weight = TAB_WEIGHT_RESET;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fused pairs other than >=, lone operators, invalid byte, strings, comment, end words
        push_text(" \t>>=<!=&&|==<=<<||/");
        push_word(8'hFF, 1'b0);
        push_text("\"a\n//x\n\"\"");
        push_word(CH_NUL, 1'b0);
        push_text("!\"b");
        push_word(8'hA5, 1'b1);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_weight((phase < 4) ? WEIGHT_PLAN[phase] : 4'($urandom_range(0, 15)));
            target = words_made + WORDS_PER_PHASE;
            while (words_made < target)
                push_random_line();
            if (phase == 1)
            begin
                @(posedge clk);
                hold_asks++;
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
